### hdl/gpe_pkg.sv
package gpe_pkg;

	// default sizing
	localparam int MAX_GLYPH_WIDTH_DEF  = 16;
	localparam int MAX_GLYPH_HEIGHT_DEF = 32;
	localparam int GLYPH_COUNT_DEF      = 256;
	localparam int FONT_STORE_BYTES_DEF = 16384;

	// register indexes
	localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;

	// actions carried in s_tuser
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_RENDER = 1'b1;

	localparam int CFG_W      = 6;
	localparam int WIDTH_W    = 5;
	localparam int HEIGHT_W   = 6;
	localparam int ADDR_IN_W  = 14;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int CHUNK_PIX  = 8;
	localparam int BASE_W     = 16;
	localparam int S_DATA_W   = 64;
	localparam int M_DATA_W   = 136;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 5'd8;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd16;

	typedef struct packed {
		logic [CHUNK_PIX-1:0][COLOR_W-1:0] pix;
		logic [COUNT_W-1:0]                count;
		logic                              last;
	} chunk_t;

endpackage

### hdl/glyph_pixel_expander.sv
// Glyph pixel expander: bitmap font character generator.
// Input words arrive on s_* (s_tuser = action). A load word (action 0) writes
// one font byte into the on-chip font store and gives no output.
// A render word (action 1) expands one character into pixel chunks on m_*:
// each glyph row yields one chunk of 8 pixels per full byte and one shorter
// chunk for the remaining width; m_tlast marks the final chunk of the glyph.
// Glyph width and height are written on the cfg_* port; the user must write
// them only while the block idles, the block itself does not enforce this.
// The CALC state subtracts the store size from a wrapping glyph offset.
// Throughput: one chunk per cycle unless the receiver stalls, limited by the
// single font store read port; s_tready stays low from a render word until
// its last store read has returned. A two-word output queue lets reads
// continue while the receiver stalls; reads pause when queue plus the read
// in flight would overflow, nothing is dropped. Reset clears control state
// and restores width 8 and height 16; the font store contents are undefined
// until loaded.
module glyph_pixel_expander
	import gpe_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = MAX_GLYPH_WIDTH_DEF,
	parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT      = GLYPH_COUNT_DEF,
	parameter int FONT_STORE_BYTES = FONT_STORE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// fields from bit 0: font_address[14], font_byte[8], char_code[8], strike,
	// underline, fg_color[16], bg_color[16]
	input  logic [S_DATA_W-1:0] s_tdata,
	// fields from bit 0: action
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// fields from bit 0: pixel_0..pixel_7[16 each], pixel_count[4], zero pad[4]
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	localparam int AW            = $clog2(FONT_STORE_BYTES);
	localparam int RW            = $clog2(MAX_GLYPH_HEIGHT);
	localparam int MAX_ROW_BYTES = (MAX_GLYPH_WIDTH + 7) / 8;
	localparam int BYTE_W        = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [WIDTH_W-1:0]  gw_q;
	logic [HEIGHT_W-1:0] gh_q;
	logic [1:0]          state_q;
	logic [BASE_W-1:0]   base_q;
	logic [AW-1:0]       addr_q;
	logic [RW-1:0]       row_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                strike_q, underline_q;
	logic [COLOR_W-1:0]  fg_q, bg_q;

	logic [7:0]          font_store [FONT_STORE_BYTES];
	logic [7:0]          rdata_s1;
	logic                rd_s1;
	logic [COUNT_W-1:0]  cnt_s1;
	logic                forced_s1, last_s1;

	chunk_t              q0_q, q1_q, new_chunk;
	logic                v0_q, v1_q;

	// field views
	logic [ADDR_IN_W-1:0] in_addr;
	logic [7:0]           in_byte;
	logic [CHAR_W-1:0]    in_char;
	assign in_addr = s_tdata[13:0];
	assign in_byte = s_tdata[21:14];
	assign in_char = s_tdata[29:22];

	// clamped geometry
	logic [WIDTH_W-1:0]  w_cl;
	logic [HEIGHT_W-1:0] h_cl;
	logic [1:0]          row_bytes;
	logic [1:0]          full_bytes;
	logic [2:0]          rem_pix;
	logic [5:0]          w_plus;

	always_comb begin
		if (gw_q == '0)
			w_cl = WIDTH_W'(1);
		else if (32'(gw_q) > MAX_GLYPH_WIDTH)
			w_cl = WIDTH_W'(MAX_GLYPH_WIDTH);
		else
			w_cl = gw_q;
		if (gh_q == '0)
			h_cl = HEIGHT_W'(1);
		else if (32'(gh_q) > MAX_GLYPH_HEIGHT)
			h_cl = HEIGHT_W'(MAX_GLYPH_HEIGHT);
		else
			h_cl = gh_q;
	end

	assign w_plus     = {1'b0, w_cl} + 6'd7;
	assign row_bytes  = w_plus[4:3];
	assign full_bytes = w_cl[4:3];
	assign rem_pix    = w_cl[2:0];

	// character wrap and glyph offset
	logic [CHAR_W:0]   ch_ext;
	logic [CHAR_W-1:0] ch_mod;
	logic [BASE_W-1:0] prod;
	logic [BASE_W-1:0] base_init;

	assign ch_ext = {1'b0, in_char};
	always_comb begin
		if (32'(ch_ext) >= GLYPH_COUNT)
			ch_mod = CHAR_W'(32'(ch_ext) - GLYPH_COUNT);
		else
			ch_mod = in_char;
	end
	assign prod      = BASE_W'(ch_mod) * BASE_W'(h_cl);
	assign base_init = (row_bytes == 2'd2) ? {prod[BASE_W-2:0], 1'b0} : prod;

	// handshake and flow control
	logic s_acc, pop, push, issue;
	logic [1:0] pending;

	assign s_tready = (state_q == ST_IDLE) && !rd_s1;
	assign s_acc    = s_tvalid && s_tready;
	assign pop      = v0_q && m_tready;
	assign push     = rd_s1;
	assign pending  = 2'(v0_q) + 2'(v1_q) + 2'(rd_s1) - 2'(pop);
	assign issue    = (state_q == ST_RUN) && (pending < 2'd2);

	// per-issue chunk attributes
	logic                row_last, byte_last, is_forced;
	logic [COUNT_W-1:0]  cnt_now;
	logic [HEIGHT_W-1:0] row_ext;

	assign row_ext   = HEIGHT_W'(row_q);
	assign row_last  = (row_ext == h_cl - HEIGHT_W'(1));
	assign byte_last = (2'(byte_q) == row_bytes - 2'd1);
	assign is_forced = (underline_q && row_last) ||
		(strike_q && (h_cl >= HEIGHT_W'(2)) &&
		(row_ext == {1'b0, h_cl[HEIGHT_W-1:1]} - HEIGHT_W'(1)));
	assign cnt_now   = (2'(byte_q) < full_bytes) ? COUNT_W'(CHUNK_PIX) : {1'b0, rem_pix};

	logic [AW:0] addr_inc;
	assign addr_inc = {1'b0, addr_q} + (AW+1)'(1);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= WIDTH_RESET;
			gh_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH_WIDTH:  gw_q <= cfg_data[WIDTH_W-1:0];
				REG_GLYPH_HEIGHT: gh_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tuser == ACT_RENDER)
						state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (32'(base_q) < FONT_STORE_BYTES)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (issue && byte_last && row_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tuser == ACT_RENDER) begin
					base_q      <= base_init;
					strike_q    <= s_tdata[30];
					underline_q <= s_tdata[31];
					fg_q        <= s_tdata[47:32];
					bg_q        <= s_tdata[63:48];
				end
			end
			ST_CALC: begin
				// fold the offset back into the store one subtraction a cycle
				if (32'(base_q) >= FONT_STORE_BYTES) begin
					base_q <= BASE_W'(32'(base_q) - FONT_STORE_BYTES);
				end else begin
					addr_q <= base_q[AW-1:0];
					row_q  <= '0;
					byte_q <= '0;
				end
			end
			ST_RUN: begin
				if (issue) begin
					if (32'(addr_inc) == FONT_STORE_BYTES)
						addr_q <= '0;
					else
						addr_q <= addr_inc[AW-1:0];
					if (byte_last) begin
						byte_q <= '0;
						row_q  <= row_q + RW'(1);
					end else begin
						byte_q <= byte_q + BYTE_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// font store
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == ACT_LOAD && 32'(in_addr) < FONT_STORE_BYTES)
			font_store[in_addr[AW-1:0]] <= in_byte;
		if (issue)
			rdata_s1 <= font_store[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_s1 <= 1'b0;
		else
			rd_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cnt_s1    <= cnt_now;
			forced_s1 <= is_forced;
			last_s1   <= byte_last && row_last;
		end
	end

	// chunk assembly, MSB is the leftmost pixel
	always_comb begin
		for (int x = 0; x < CHUNK_PIX; x++) begin
			if (x < 32'(cnt_s1))
				new_chunk.pix[x] = (forced_s1 || rdata_s1[7-x]) ? fg_q : bg_q;
			else
				new_chunk.pix[x] = '0;
		end
		new_chunk.count = cnt_s1;
		new_chunk.last  = last_s1;
	end

	// two-word output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (push && pop) begin
				v0_q <= 1'b1;
			end else if (push) begin
				if (v0_q)
					v1_q <= 1'b1;
				else
					v0_q <= 1'b1;
			end else if (pop) begin
				v0_q <= v1_q;
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (v1_q) begin
				q0_q <= q1_q;
				q1_q <= new_chunk;
			end else begin
				q0_q <= new_chunk;
			end
		end else if (push) begin
			if (v0_q)
				q1_q <= new_chunk;
			else
				q0_q <= new_chunk;
		end else if (pop) begin
			q0_q <= q1_q;
		end
	end

	assign m_tvalid = v0_q;
	assign m_tdata  = {4'b0, q0_q.count, q0_q.pix};
	assign m_tlast  = q0_q.last;

endmodule

### hdl/gpe_checker.sv
module gpe_checker
	import gpe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	// output queue is empty while in reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output word valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[131:128] != 4'd0) && (m_tdata[131:128] <= 4'd8))
		else $error("pixel count out of range");

	// a short chunk leaves the last slot clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[131:128] != 4'd8) |-> m_tdata[127:112] == 16'd0)
		else $error("unused pixel slot not zero");

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_RENDER) |=> !s_tready)
		else $error("input taken during render");

endmodule

bind glyph_pixel_expander gpe_checker u_gpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
